[src/dbhp_pkg.sv]
// Shared types, constants and decode functions for the database file header parser.
// Used by every module of the parser; depends on nothing else.
`default_nettype none

package dbhp_pkg;

  localparam int unsigned HDR_LEN   = 100;
  localparam int unsigned MAGIC_LEN = 16;

  localparam logic [15:0] PAGE_MIN      = 16'd512;
  localparam logic [15:0] PAGE_CODE_MAX = 16'd1;
  localparam logic [31:0] PAGE_MAX      = 32'd65536;

  localparam logic [6:0] OFF_PAGE_LAST  = 7'd17;
  localparam logic [6:0] OFF_BYTE_FIRST = 7'd18;
  localparam logic [6:0] OFF_BYTE_LAST  = 7'd20;
  localparam logic [6:0] OFF_FINAL      = 7'(HDR_LEN - 1);

  localparam logic [3:0] FIELD_PAGE_SIZE = 4'd0;

  localparam logic KIND_FIELD   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_BAD_MAGIC = 2'd1,
    VERDICT_BAD_PAGE  = 2'd2,
    VERDICT_TRUNCATED = 2'd3
  } verdict_t;

  // One queue entry holds everything that one header byte produces.
  typedef struct packed {
    logic        has_field;
    logic [3:0]  field_id;
    logic [31:0] field_value;
    logic        has_verdict;
    verdict_t    verdict;
  } dbhp_entry_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] id;
  } word_end_t;

  // Expected magic string byte at offsets 0 to 15.
  function automatic logic [7:0] magic_byte(input logic [3:0] off);
    logic [7:0] b;
    unique case (off)
      4'd0:    b = 8'h53;
      4'd1:    b = 8'h51;
      4'd2:    b = 8'h4C;
      4'd3:    b = 8'h69;
      4'd4:    b = 8'h74;
      4'd5:    b = 8'h65;
      4'd6:    b = 8'h20;
      4'd7:    b = 8'h66;
      4'd8:    b = 8'h6F;
      4'd9:    b = 8'h72;
      4'd10:   b = 8'h6D;
      4'd11:   b = 8'h61;
      4'd12:   b = 8'h74;
      4'd13:   b = 8'h20;
      4'd14:   b = 8'h33;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Offsets that close one of the ten big-endian word fields.
  function automatic word_end_t word_end(input logic [6:0] off);
    word_end_t w;
    w.hit = 1'b1;
    unique case (off)
      7'd27:   w.id = 4'd4;
      7'd31:   w.id = 4'd5;
      7'd35:   w.id = 4'd6;
      7'd39:   w.id = 4'd7;
      7'd43:   w.id = 4'd8;
      7'd47:   w.id = 4'd9;
      7'd59:   w.id = 4'd10;
      7'd63:   w.id = 4'd11;
      7'd71:   w.id = 4'd12;
      7'd99:   w.id = 4'd13;
      default: begin
        w.hit = 1'b0;
        w.id  = 4'd0;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[src/dbhp_front.sv]
// Front end of the header parser: takes bytes, tracks the offset and accumulator,
// and classifies each byte, turning any result into a queue entry. Depends on dbhp_pkg.
`default_nettype none

module dbhp_front
  import dbhp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  header_byte,
  input  wire logic        starts_header,
  input  wire logic        buffer_end,
  input  wire logic        queue_full,
  output logic             push,
  output dbhp_entry_t      push_entry
);

  logic [6:0]  byte_offset, byte_offset_next;
  logic        header_closed, header_closed_next;
  logic [31:0] word_accumulator, word_accumulator_next;

  logic        accept;
  logic        active;
  logic [6:0]  off;
  logic [31:0] acc_shift;
  logic [15:0] ps_raw;
  logic [15:0] ps_minus_one;
  logic        page_ok;
  logic [6:0]  byte_field_id;
  word_end_t   wend;
  dbhp_entry_t entry;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign active   = starts_header || !header_closed;
  assign off      = starts_header ? 7'd0 : byte_offset;
  assign acc_shift = {(starts_header ? 24'd0 : word_accumulator[23:0]), header_byte};

  assign ps_raw        = acc_shift[15:0];
  assign ps_minus_one  = ps_raw - 16'd1;
  // Code 1 stands for 65536; otherwise a power of two of at least 512.
  assign page_ok = (ps_raw == PAGE_CODE_MAX) ||
                   ((ps_raw != 16'd0) && ((ps_raw & ps_minus_one) == 16'd0) &&
                    (ps_raw >= PAGE_MIN));
  assign byte_field_id = off - OFF_PAGE_LAST;
  assign wend          = word_end(off);

  always_comb begin
    entry                   = '0;
    entry.verdict           = VERDICT_OK;
    byte_offset_next        = byte_offset;
    header_closed_next      = header_closed;
    word_accumulator_next   = word_accumulator;
    if (accept && active) begin
      word_accumulator_next = acc_shift;
      header_closed_next    = 1'b0;
      if (off < 7'(MAGIC_LEN)) begin
        if (header_byte != magic_byte(off[3:0])) begin
          entry.has_verdict = 1'b1;
          entry.verdict     = VERDICT_BAD_MAGIC;
        end
      end else if (off == OFF_PAGE_LAST) begin
        if (!page_ok) begin
          entry.has_verdict = 1'b1;
          entry.verdict     = VERDICT_BAD_PAGE;
        end else begin
          entry.has_field   = 1'b1;
          entry.field_id    = FIELD_PAGE_SIZE;
          entry.field_value = (ps_raw == PAGE_CODE_MAX) ? PAGE_MAX : {16'd0, ps_raw};
        end
      end else if (off >= OFF_BYTE_FIRST && off <= OFF_BYTE_LAST) begin
        entry.has_field   = 1'b1;
        entry.field_id    = byte_field_id[3:0];
        entry.field_value = {24'd0, header_byte};
      end else if (wend.hit) begin
        entry.has_field   = 1'b1;
        entry.field_id    = wend.id;
        entry.field_value = acc_shift;
      end

      // A magic or page size failure outranks truncation on the same byte.
      if (!entry.has_verdict) begin
        if (off >= OFF_FINAL) begin
          entry.has_verdict = 1'b1;
          entry.verdict     = VERDICT_OK;
        end else if (buffer_end) begin
          entry.has_verdict = 1'b1;
          entry.verdict     = VERDICT_TRUNCATED;
        end
      end

      if (entry.has_verdict) begin
        header_closed_next = 1'b1;
        byte_offset_next   = 7'd0;
      end else begin
        byte_offset_next   = off + 7'd1;
      end
    end
  end

  assign push       = accept && active && (entry.has_field || entry.has_verdict);
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset      <= 7'd0;
      header_closed    <= 1'b1;
      word_accumulator <= 32'd0;
    end else begin
      byte_offset      <= byte_offset_next;
      header_closed    <= header_closed_next;
      word_accumulator <= word_accumulator_next;
    end
  end

endmodule

`default_nettype wire

[src/dbhp_queue.sv]
// Short entry queue that decouples the front end from the result sequencer.
// Depends on dbhp_pkg for the entry type.
`default_nettype none

module dbhp_queue
  import dbhp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire dbhp_entry_t push_entry,
  output logic             full,
  input  wire logic        pop,
  output dbhp_entry_t      pop_entry,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  dbhp_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/dbhp_back.sv]
// Result sequencer: drains queue entries and drives the registered result port,
// splitting an entry with a field and a verdict into two transactions. Depends on dbhp_pkg.
`default_nettype none

module dbhp_back
  import dbhp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dbhp_entry_t head_entry,
  input  wire logic        queue_empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [3:0]       field_id,
  output logic [31:0]      field_value,
  output logic [1:0]       verdict,
  output logic             last
);

  logic     load_ok;
  logic     pend_verdict;
  verdict_t pend_code;

  assign load_ok = !out_valid || !out_stall;
  assign pop     = load_ok && !pend_verdict && !queue_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      pend_verdict <= 1'b0;
    end else if (load_ok) begin
      if (pend_verdict) begin
        out_valid    <= 1'b1;
        pend_verdict <= 1'b0;
      end else if (!queue_empty) begin
        out_valid    <= 1'b1;
        pend_verdict <= head_entry.has_field && head_entry.has_verdict;
      end else begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (pend_verdict || (!queue_empty && !head_entry.has_field)) begin
        result_kind <= KIND_VERDICT;
        field_id    <= 4'd0;
        field_value <= 32'd0;
        verdict     <= pend_verdict ? pend_code : head_entry.verdict;
        last        <= 1'b1;
      end else if (!queue_empty) begin
        result_kind <= KIND_FIELD;
        field_id    <= head_entry.field_id;
        field_value <= head_entry.field_value;
        verdict     <= VERDICT_OK;
        last        <= 1'b0;
      end
      if (pop) begin
        pend_code <= head_entry.verdict;
      end
    end
  end

endmodule

`default_nettype wire

[src/database_file_header_parser.sv]
// Database file header parser, top level. Takes one header byte per cycle unless the queue is full.
// An accepted byte's result is written into the entry queue and then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full; the byte that carries both a field
// and a verdict occupies the result port for two transactions, and the entry queue absorbs that.
// Reset (synchronous, rst high) empties the queue and the output register and leaves
// the parser closed, waiting for a byte marked as a header start.
`default_nettype none

module database_file_header_parser
  import dbhp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  header_byte,
  input  wire logic        starts_header,
  input  wire logic        buffer_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [3:0]       field_id,
  output logic [31:0]      field_value,
  output logic [1:0]       verdict,
  output logic             last
);

  // The front end classifies each accepted byte in the cycle it arrives. A byte that
  // yields any result becomes one queue entry; ignored bytes leave no trace. The front
  // end stalls its input only when the queue is full, so a stalled result port does not
  // block the byte stream until the queue fills up.
  logic        push;
  logic        pop;
  logic        queue_full;
  logic        queue_empty;
  dbhp_entry_t push_entry;
  dbhp_entry_t head_entry;

  dbhp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .header_byte   (header_byte),
    .starts_header (starts_header),
    .buffer_end    (buffer_end),
    .queue_full    (queue_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  dbhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .pop_entry  (head_entry),
    .empty      (queue_empty)
  );

  // The back end issues a field transaction first and then the verdict transaction
  // when one byte produced both.
  dbhp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_entry  (head_entry),
    .queue_empty (queue_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .field_id    (field_id),
    .field_value (field_value),
    .verdict     (verdict),
    .last        (last)
  );

endmodule

`default_nettype wire
